FILE: hdl/cdsc_pkg.sv
// ============================================================================
// cdsc_pkg
// Shared types, constants and helper functions of the clock display and
// set controller: mode codes, the queued tick record and segment encoding.
// ============================================================================
`default_nettype none

package cdsc_pkg;

    localparam int          QUEUE_DEPTH       = 2;
    localparam logic [15:0] BLINK_HALF_RESET  = 16'd500;

    localparam logic [7:0]  SEG_M_GLYPH       = 8'h37;
    localparam logic [7:0]  SEG_DASH          = 8'h40;
    localparam logic [7:0]  SEG_BLANK         = 8'h00;
    localparam logic [3:0]  GLYPH_D_INDEX     = 4'hD;

    localparam logic [6:0]  HOUR_MAX          = 7'd23;
    localparam logic [6:0]  MINUTE_MAX        = 7'd59;
    localparam logic [6:0]  YEAR_MAX          = 7'd99;
    localparam logic [6:0]  MONTH_MAX         = 7'd12;
    localparam logic [6:0]  LONG_MONTH_DAYS   = 7'd31;

    // Configuration register indexes.
    localparam logic        REG_BLINK_HALF    = 1'b0;

    typedef enum logic [3:0] {
        MODE_SHOW_TIME   = 4'd0,
        MODE_SHOW_YEAR   = 4'd1,
        MODE_SHOW_MONTH  = 4'd2,
        MODE_SHOW_DAY    = 4'd3,
        MODE_SET_HOURS   = 4'd4,
        MODE_SET_MINUTES = 4'd5,
        MODE_SET_DAY     = 4'd6,
        MODE_SET_MONTH   = 4'd7,
        MODE_SET_YEAR    = 4'd8
    } t_mode;

    // One classified tick as handed from the front to the back.
    typedef struct packed {
        t_mode      mode;
        logic       blink_on;
        logic       colon;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       plus;
        logic       minus;
    } t_tick;

    function automatic logic [7:0] seg_hex(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'h0: seg = 8'h3F;
            4'h1: seg = 8'h06;
            4'h2: seg = 8'h5B;
            4'h3: seg = 8'h4F;
            4'h4: seg = 8'h66;
            4'h5: seg = 8'h6D;
            4'h6: seg = 8'h7D;
            4'h7: seg = 8'h07;
            4'h8: seg = 8'h7F;
            4'h9: seg = 8'h6F;
            4'hA: seg = 8'h77;
            4'hB: seg = 8'h7C;
            4'hC: seg = 8'h39;
            4'hD: seg = 8'h5E;
            4'hE: seg = 8'h79;
            default: seg = 8'h71;
        endcase
        return seg;
    endfunction

    // Division by ten through the reciprocal 205/2048, exact far beyond 127.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] rem;
        rem = v - 7'(tens_of(v) * 7'd10);
        return rem[3:0];
    endfunction

    function automatic logic [6:0] days_in_month(input logic [3:0] month);
        logic [6:0] len;
        unique case (month)
            4'd2:                      len = 7'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 7'd30;
            default:                   len = LONG_MONTH_DAYS;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cdsc_front.sv
// ============================================================================
// cdsc_front
// Accepts service ticks, advances the mode, blink phase and short-press
// lock, and pushes a classified tick record toward the back end.
// ============================================================================
`default_nettype none

module cdsc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_blink_half,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_time_ms,
    input  wire logic [4:0]    i_cur_hour,
    input  wire logic [5:0]    i_cur_minute,
    input  wire logic [4:0]    i_cur_day,
    input  wire logic [3:0]    i_cur_month,
    input  wire logic [6:0]    i_cur_year,
    input  wire logic          i_set_long_press,
    input  wire logic          i_set_released,
    input  wire logic          i_set_pressed,
    input  wire logic          i_plus_pressed,
    input  wire logic          i_minus_pressed,
    output logic               o_push_valid,
    input  wire logic          i_push_ready,
    output cdsc_pkg::t_tick    o_push_data
);

    cdsc_pkg::t_mode r_mode, n_mode;
    logic [31:0]     r_blink_start;
    logic            r_blink_phase;
    logic            r_lock, n_lock;

    logic [31:0] elapsed;
    logic        toggle;
    logic        phase_now;
    logic        is_set_mode;
    logic        edit;
    logic        colon;
    logic        accept;

    assign accept       = i_valid && i_push_ready;
    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;

    always_comb begin
        elapsed   = i_time_ms - r_blink_start;
        toggle    = (elapsed >= {16'h0000, i_blink_half});
        phase_now = r_blink_phase ^ toggle;

        is_set_mode = (r_mode == cdsc_pkg::MODE_SET_HOURS)
                   || (r_mode == cdsc_pkg::MODE_SET_MINUTES)
                   || (r_mode == cdsc_pkg::MODE_SET_DAY)
                   || (r_mode == cdsc_pkg::MODE_SET_MONTH)
                   || (r_mode == cdsc_pkg::MODE_SET_YEAR);
        edit = is_set_mode && (i_plus_pressed || i_minus_pressed);

        n_mode = r_mode;
        n_lock = r_lock;
        colon  = 1'b0;
        unique case (r_mode)
            cdsc_pkg::MODE_SHOW_TIME: begin
                colon = phase_now;
                if (i_set_long_press) begin
                    n_mode = cdsc_pkg::MODE_SET_HOURS;
                end else if (i_set_released) begin
                    // The release that ends the last set press is swallowed once.
                    if (r_lock) begin
                        n_lock = 1'b0;
                    end else begin
                        n_mode = cdsc_pkg::MODE_SHOW_YEAR;
                    end
                end
            end
            cdsc_pkg::MODE_SHOW_YEAR: begin
                if (i_set_long_press)    n_mode = cdsc_pkg::MODE_SET_YEAR;
                else if (i_set_released) n_mode = cdsc_pkg::MODE_SHOW_MONTH;
            end
            cdsc_pkg::MODE_SHOW_MONTH: begin
                if (i_set_long_press)    n_mode = cdsc_pkg::MODE_SET_MONTH;
                else if (i_set_released) n_mode = cdsc_pkg::MODE_SHOW_DAY;
            end
            cdsc_pkg::MODE_SHOW_DAY: begin
                if (i_set_long_press)    n_mode = cdsc_pkg::MODE_SET_DAY;
                else if (i_set_released) n_mode = cdsc_pkg::MODE_SHOW_TIME;
            end
            cdsc_pkg::MODE_SET_HOURS: begin
                colon = 1'b1;
                if (i_set_pressed) n_mode = cdsc_pkg::MODE_SET_MINUTES;
            end
            cdsc_pkg::MODE_SET_MINUTES: begin
                colon = 1'b1;
                if (i_set_pressed) n_mode = cdsc_pkg::MODE_SET_YEAR;
            end
            cdsc_pkg::MODE_SET_YEAR: begin
                if (i_set_pressed) n_mode = cdsc_pkg::MODE_SET_MONTH;
            end
            cdsc_pkg::MODE_SET_MONTH: begin
                if (i_set_pressed) n_mode = cdsc_pkg::MODE_SET_DAY;
            end
            cdsc_pkg::MODE_SET_DAY: begin
                if (i_set_pressed) begin
                    n_mode = cdsc_pkg::MODE_SHOW_TIME;
                    n_lock = 1'b1;
                end
            end
            default: begin
                n_mode = cdsc_pkg::MODE_SHOW_TIME;
            end
        endcase

        o_push_data.mode     = r_mode;
        o_push_data.blink_on = phase_now;
        o_push_data.colon    = colon;
        o_push_data.hour     = i_cur_hour;
        o_push_data.minute   = i_cur_minute;
        o_push_data.day      = i_cur_day;
        o_push_data.month    = i_cur_month;
        o_push_data.year     = i_cur_year;
        o_push_data.plus     = i_plus_pressed;
        o_push_data.minus    = i_minus_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cdsc_pkg::MODE_SHOW_TIME;
            r_blink_start <= 32'h0000_0000;
            r_blink_phase <= 1'b0;
            r_lock        <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_lock <= n_lock;
            if (toggle || edit) begin
                r_blink_start <= i_time_ms;
            end
            // An edit restarts the blink with the field visible.
            r_blink_phase <= edit ? 1'b1 : phase_now;
        end
    end

    a_edit_shows_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && edit) |=> (r_blink_phase && (r_blink_start == $past(i_time_ms))))
        else $error("blink did not restart after an edit");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_mode) && $stable(r_blink_phase) && $stable(r_lock)))
        else $error("front state moved without a transfer");

    a_lock_set_by_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_lock) |-> ($past(r_mode) == cdsc_pkg::MODE_SET_DAY))
        else $error("short-press lock set outside set-day mode");

endmodule

`default_nettype wire

FILE: hdl/cdsc_queue.sv
// ============================================================================
// cdsc_queue
// Small register FIFO between the front and back ends of the controller.
// ============================================================================
`default_nettype none

module cdsc_queue #(
    parameter int DEPTH = cdsc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire cdsc_pkg::t_tick i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output cdsc_pkg::t_tick    o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdsc_pkg::t_tick r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

FILE: hdl/cdsc_back.sv
// ============================================================================
// cdsc_back
// Renders the four digits, applies plus and minus edits to the field being
// set, and holds the result in the output register.
// ============================================================================
`default_nettype none

module cdsc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop_valid,
    output logic               o_pop_ready,
    input  wire cdsc_pkg::t_tick i_pop_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_digit0_segments,
    output logic [7:0]         o_digit1_segments,
    output logic [7:0]         o_digit2_segments,
    output logic [7:0]         o_digit3_segments,
    output logic               o_colon_on,
    output logic               o_write_clock,
    output logic [4:0]         o_new_hour,
    output logic [5:0]         o_new_minute,
    output logic [4:0]         o_new_day,
    output logic [3:0]         o_new_month,
    output logic [6:0]         o_new_year
);

    function automatic logic [6:0] step_up(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
        return (v < hi) ? v + 7'd1 : lo;
    endfunction

    function automatic logic [6:0] step_down(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi);
        return (v > lo) ? v - 7'd1 : hi;
    endfunction

    function automatic logic [6:0] edit_field(input logic [6:0] v, input logic plus,
                                              input logic minus, input logic [6:0] lo,
                                              input logic [6:0] hi);
        logic [6:0] w;
        w = plus ? step_up(v, lo, hi) : v;
        return minus ? step_down(w, lo, hi) : w;
    endfunction

    logic        r_valid;
    logic [7:0]  r_d0, r_d1, r_d2, r_d3;
    logic        r_colon;
    logic        r_write;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [6:0]  r_year;

    logic [7:0]  n_d0, n_d1, n_d2, n_d3;
    logic        n_colon;
    logic        n_write;
    logic [6:0]  n_hour, n_minute, n_day, n_month, n_year;

    logic [6:0]  hr7, mi7, dy7, mo7, yr7;
    logic [7:0]  hr_t, hr_o, mi_t, mi_o, dy_t, dy_o, mo_t, mo_o, yr_t, yr_o;
    logic [6:0]  month_len;
    logic        edits;
    logic        load;

    assign load        = !r_valid || i_ready;
    assign o_pop_ready = load;

    always_comb begin
        hr7 = {2'b00, i_pop_data.hour};
        mi7 = {1'b0, i_pop_data.minute};
        dy7 = {2'b00, i_pop_data.day};
        mo7 = {3'b000, i_pop_data.month};
        yr7 = i_pop_data.year;

        hr_t = cdsc_pkg::seg_hex(cdsc_pkg::tens_of(hr7));
        hr_o = cdsc_pkg::seg_hex(cdsc_pkg::ones_of(hr7));
        mi_t = cdsc_pkg::seg_hex(cdsc_pkg::tens_of(mi7));
        mi_o = cdsc_pkg::seg_hex(cdsc_pkg::ones_of(mi7));
        dy_t = cdsc_pkg::seg_hex(cdsc_pkg::tens_of(dy7));
        dy_o = cdsc_pkg::seg_hex(cdsc_pkg::ones_of(dy7));
        mo_t = cdsc_pkg::seg_hex(cdsc_pkg::tens_of(mo7));
        mo_o = cdsc_pkg::seg_hex(cdsc_pkg::ones_of(mo7));
        yr_t = cdsc_pkg::seg_hex(cdsc_pkg::tens_of(yr7));
        yr_o = cdsc_pkg::seg_hex(cdsc_pkg::ones_of(yr7));

        // A month code outside one to twelve counts as a long month.
        month_len = cdsc_pkg::days_in_month(i_pop_data.month);
        if ((i_pop_data.month == 4'd2) && (i_pop_data.year[1:0] == 2'b00)) begin
            month_len = month_len + 7'd1;
        end

        edits    = i_pop_data.plus || i_pop_data.minus;
        n_d0     = cdsc_pkg::SEG_BLANK;
        n_d1     = cdsc_pkg::SEG_BLANK;
        n_d2     = cdsc_pkg::SEG_BLANK;
        n_d3     = cdsc_pkg::SEG_BLANK;
        n_colon  = i_pop_data.colon;
        n_write  = 1'b0;
        n_hour   = hr7;
        n_minute = mi7;
        n_day    = dy7;
        n_month  = mo7;
        n_year   = yr7;

        unique case (i_pop_data.mode)
            cdsc_pkg::MODE_SHOW_TIME: begin
                n_d0 = hr_t; n_d1 = hr_o; n_d2 = mi_t; n_d3 = mi_o;
            end
            cdsc_pkg::MODE_SHOW_YEAR: begin
                n_d0 = cdsc_pkg::seg_hex(4'd2); n_d1 = cdsc_pkg::seg_hex(4'd0);
                n_d2 = yr_t; n_d3 = yr_o;
            end
            cdsc_pkg::MODE_SHOW_MONTH: begin
                n_d0 = cdsc_pkg::SEG_M_GLYPH; n_d2 = mo_t; n_d3 = mo_o;
            end
            cdsc_pkg::MODE_SHOW_DAY: begin
                n_d0 = cdsc_pkg::seg_hex(cdsc_pkg::GLYPH_D_INDEX);
                n_d2 = dy_t; n_d3 = dy_o;
            end
            cdsc_pkg::MODE_SET_HOURS: begin
                if (i_pop_data.blink_on) begin
                    n_d0 = hr_t; n_d1 = hr_o;
                end
                n_d2    = mi_t; n_d3 = mi_o;
                n_write = edits;
                n_hour  = edit_field(hr7, i_pop_data.plus, i_pop_data.minus,
                                     7'd0, cdsc_pkg::HOUR_MAX);
            end
            cdsc_pkg::MODE_SET_MINUTES: begin
                n_d0 = hr_t; n_d1 = hr_o;
                if (i_pop_data.blink_on) begin
                    n_d2 = mi_t; n_d3 = mi_o;
                end
                n_write  = edits;
                n_minute = edit_field(mi7, i_pop_data.plus, i_pop_data.minus,
                                      7'd0, cdsc_pkg::MINUTE_MAX);
            end
            cdsc_pkg::MODE_SET_YEAR: begin
                if (i_pop_data.blink_on) begin
                    n_d0 = cdsc_pkg::seg_hex(4'd2); n_d1 = cdsc_pkg::seg_hex(4'd0);
                    n_d2 = yr_t; n_d3 = yr_o;
                end
                n_write = edits;
                n_year  = edit_field(yr7, i_pop_data.plus, i_pop_data.minus,
                                     7'd0, cdsc_pkg::YEAR_MAX);
            end
            cdsc_pkg::MODE_SET_MONTH: begin
                n_d0 = cdsc_pkg::SEG_M_GLYPH;
                if (i_pop_data.blink_on) begin
                    n_d2 = mo_t; n_d3 = mo_o;
                end
                n_write = edits;
                n_month = edit_field(mo7, i_pop_data.plus, i_pop_data.minus,
                                     7'd1, cdsc_pkg::MONTH_MAX);
            end
            cdsc_pkg::MODE_SET_DAY: begin
                n_d0 = cdsc_pkg::seg_hex(cdsc_pkg::GLYPH_D_INDEX);
                if (i_pop_data.blink_on) begin
                    n_d2 = dy_t; n_d3 = dy_o;
                end
                n_write = edits;
                n_day   = edit_field(dy7, i_pop_data.plus, i_pop_data.minus,
                                     7'd1, month_len);
            end
            default: begin
                n_d0    = cdsc_pkg::SEG_DASH;
                n_d1    = cdsc_pkg::SEG_DASH;
                n_d2    = cdsc_pkg::SEG_DASH;
                n_d3    = cdsc_pkg::SEG_DASH;
                n_colon = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_pop_valid) begin
            r_d0     <= n_d0;
            r_d1     <= n_d1;
            r_d2     <= n_d2;
            r_d3     <= n_d3;
            r_colon  <= n_colon;
            r_write  <= n_write;
            // The write fields read zero when no write is requested.
            r_hour   <= n_write ? n_hour[4:0]   : 5'd0;
            r_minute <= n_write ? n_minute[5:0] : 6'd0;
            r_day    <= n_write ? n_day[4:0]    : 5'd0;
            r_month  <= n_write ? n_month[3:0]  : 4'd0;
            r_year   <= n_write ? n_year        : 7'd0;
        end
    end

    assign o_valid           = r_valid;
    assign o_digit0_segments = r_d0;
    assign o_digit1_segments = r_d1;
    assign o_digit2_segments = r_d2;
    assign o_digit3_segments = r_d3;
    assign o_colon_on        = r_colon;
    assign o_write_clock     = r_write;
    assign o_new_hour        = r_hour;
    assign o_new_minute      = r_minute;
    assign o_new_day         = r_day;
    assign o_new_month       = r_month;
    assign o_new_year        = r_year;

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_write) |-> ((r_hour == 5'd0) && (r_minute == 6'd0)
            && (r_day == 5'd0) && (r_month == 4'd0) && (r_year == 7'd0)))
        else $error("write fields not cleared without a write");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop_valid && o_pop_ready) |=> r_valid)
        else $error("popped tick did not reach the output register");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_d0) && $stable(r_d3)
            && $stable(r_colon) && $stable(r_write) && $stable(r_hour)))
        else $error("result changed while the output was stalled");

endmodule

`default_nettype wire

FILE: hdl/clock_display_set_controller.sv
// ============================================================================
// clock_display_set_controller
// Service-tick driven clock display controller: mode sequencing, blinking,
// seven-segment rendering and date/time editing with a register port.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ------------------------------
//  tick in   input      i_valid / o_ready         i_time_ms .. i_minus_pressed
//  result    output     o_valid / i_ready         o_digit0_segments .. o_new_year
//  config    input      psel/penable/pwrite/pready blink half period at address 0
//
//  One tick is taken per cycle while the queue has room; with an empty queue its
//  result passes through the queue entry and then into the output register.
//  While the output is stalled up to QUEUE_DEPTH ticks wait in the queue, and
//  the input stalls once it is full.
//  Synchronous active-low reset restores show time, blink off, lock clear, an
//  empty queue and a 500 ms half period.
// ============================================================================
`default_nettype none

module clock_display_set_controller #(
    parameter int QUEUE_DEPTH = cdsc_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [31:0]   i_time_ms,
    input  wire logic [4:0]    i_cur_hour,
    input  wire logic [5:0]    i_cur_minute,
    input  wire logic [4:0]    i_cur_day,
    input  wire logic [3:0]    i_cur_month,
    input  wire logic [6:0]    i_cur_year,
    input  wire logic          i_set_long_press,
    input  wire logic          i_set_released,
    input  wire logic          i_set_pressed,
    input  wire logic          i_plus_pressed,
    input  wire logic          i_minus_pressed,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_digit0_segments,
    output logic [7:0]         o_digit1_segments,
    output logic [7:0]         o_digit2_segments,
    output logic [7:0]         o_digit3_segments,
    output logic               o_colon_on,
    output logic               o_write_clock,
    output logic [4:0]         o_new_hour,
    output logic [5:0]         o_new_minute,
    output logic [4:0]         o_new_day,
    output logic [3:0]         o_new_month,
    output logic [6:0]         o_new_year
);

    logic [15:0]     r_blink_half;
    logic            cfg_write;
    logic            push_valid;
    logic            push_ready;
    cdsc_pkg::t_tick push_data;
    logic            pop_valid;
    logic            pop_ready;
    cdsc_pkg::t_tick pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = 32'h0000_0000;
        if (paddr[2] == cdsc_pkg::REG_BLINK_HALF) begin
            prdata = {16'h0000, r_blink_half};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_half <= cdsc_pkg::BLINK_HALF_RESET;
        end else if (cfg_write && (paddr[2] == cdsc_pkg::REG_BLINK_HALF)) begin
            r_blink_half <= pwdata[15:0];
        end
    end

    cdsc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_blink_half     (r_blink_half),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_time_ms        (i_time_ms),
        .i_cur_hour       (i_cur_hour),
        .i_cur_minute     (i_cur_minute),
        .i_cur_day        (i_cur_day),
        .i_cur_month      (i_cur_month),
        .i_cur_year       (i_cur_year),
        .i_set_long_press (i_set_long_press),
        .i_set_released   (i_set_released),
        .i_set_pressed    (i_set_pressed),
        .i_plus_pressed   (i_plus_pressed),
        .i_minus_pressed  (i_minus_pressed),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_data      (push_data)
    );

    cdsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    cdsc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pop_valid       (pop_valid),
        .o_pop_ready       (pop_ready),
        .i_pop_data        (pop_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_digit0_segments (o_digit0_segments),
        .o_digit1_segments (o_digit1_segments),
        .o_digit2_segments (o_digit2_segments),
        .o_digit3_segments (o_digit3_segments),
        .o_colon_on        (o_colon_on),
        .o_write_clock     (o_write_clock),
        .o_new_hour        (o_new_hour),
        .o_new_minute      (o_new_minute),
        .o_new_day         (o_new_day),
        .o_new_month       (o_new_month),
        .o_new_year        (o_new_year)
    );

    a_cfg_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && (paddr[2] == cdsc_pkg::REG_BLINK_HALF))
            |=> (r_blink_half == $past(pwdata[15:0])))
        else $error("blink half period write lost");

    a_ready_follows_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && !pop_valid && push_valid && push_ready)
            |=> pop_valid)
        else $error("transfer did not enter the queue");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_ready) |-> (o_valid && pop_valid))
        else $error("input stalled while the back end can drain");

endmodule

`default_nettype wire

FILE: verif/cdsc_display_checker.sv
// ============================================================================
// cdsc_display_checker
// Watches the tick, result and register ports of the clock display and set
// controller. Keeps its own copy of the mode, blink and lock state, predicts
// the display frame and clock write of every tick transfer, and compares
// each result transfer with the oldest prediction, field by field.
// ============================================================================
module cdsc_display_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [31:0] i_time_ms,
    input  logic [4:0]  i_cur_hour,
    input  logic [5:0]  i_cur_minute,
    input  logic [4:0]  i_cur_day,
    input  logic [3:0]  i_cur_month,
    input  logic [6:0]  i_cur_year,
    input  logic        i_set_long_press,
    input  logic        i_set_released,
    input  logic        i_set_pressed,
    input  logic        i_plus_pressed,
    input  logic        i_minus_pressed,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_digit0_segments,
    input  logic [7:0]  o_digit1_segments,
    input  logic [7:0]  o_digit2_segments,
    input  logic [7:0]  o_digit3_segments,
    input  logic        o_colon_on,
    input  logic        o_write_clock,
    input  logic [4:0]  o_new_hour,
    input  logic [5:0]  o_new_minute,
    input  logic [4:0]  o_new_day,
    input  logic [3:0]  o_new_month,
    input  logic [6:0]  o_new_year,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count,
    output int          clock_writes,
    output logic [8:0]  modes_seen
);

    localparam logic [2:0] BLINK_HALF_ADDR = 3'(4 * cdsc_pkg::REG_BLINK_HALF);

    localparam logic [7:0] HEX_GLYPH [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    localparam int MONTH_LENGTHS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [7:0] seg0;
        logic [7:0] seg1;
        logic [7:0] seg2;
        logic [7:0] seg3;
        logic       colon;
        logic       wr;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_display_frame;

    t_display_frame expected_frames [$];

    cdsc_pkg::t_mode mode_now;
    logic [31:0]     blink_mark_ms;
    logic            blink_lit;
    logic            release_lock;
    logic [15:0]     half_period_ms;

    function automatic logic [7:0] tens_glyph(input int v);
        return HEX_GLYPH[(v / 10) % 16];
    endfunction

    function automatic logic [7:0] ones_glyph(input int v);
        return HEX_GLYPH[v % 10];
    endfunction

    // A value above the upper bound wraps to the lower bound on the way up.
    function automatic int wrap_up(input int v, input int lo, input int hi);
        return (v < hi) ? v + 1 : lo;
    endfunction

    function automatic int wrap_down(input int v, input int lo, input int hi);
        return (v > lo) ? v - 1 : hi;
    endfunction

    // Advances the mode, blink and lock state by one tick and returns the frame.
    function automatic t_display_frame render_and_edit(
        input logic [31:0] now_ms,
        input logic [4:0]  hr,
        input logic [5:0]  mi,
        input logic [4:0]  dy,
        input logic [3:0]  mo,
        input logic [6:0]  yr,
        input logic        lng,
        input logic        rel,
        input logic        prs,
        input logic        plus,
        input logic        minus
    );
        t_display_frame f;
        logic [4:0] hr_w;
        logic [5:0] mi_w;
        logic [4:0] dy_w;
        logic [3:0] mo_w;
        logic [6:0] yr_w;
        logic       edited;
        int         month_len;
        f      = '0;
        hr_w   = hr;
        mi_w   = mi;
        dy_w   = dy;
        mo_w   = mo;
        yr_w   = yr;
        edited = 1'b0;

        if (now_ms - blink_mark_ms >= 32'(half_period_ms)) begin
            blink_mark_ms = now_ms;
            blink_lit     = ~blink_lit;
        end

        case (mode_now)
            cdsc_pkg::MODE_SHOW_TIME: begin
                f.seg0  = tens_glyph(hr);
                f.seg1  = ones_glyph(hr);
                f.seg2  = tens_glyph(mi);
                f.seg3  = ones_glyph(mi);
                f.colon = blink_lit;
                if (lng) begin
                    mode_now = cdsc_pkg::MODE_SET_HOURS;
                end else if (rel) begin
                    // The release that ends a set sequence must not advance the mode.
                    if (release_lock) release_lock = 1'b0;
                    else mode_now = cdsc_pkg::MODE_SHOW_YEAR;
                end
            end
            cdsc_pkg::MODE_SHOW_YEAR: begin
                f.seg0 = HEX_GLYPH[2];
                f.seg1 = HEX_GLYPH[0];
                f.seg2 = tens_glyph(yr);
                f.seg3 = ones_glyph(yr);
                if (lng) mode_now = cdsc_pkg::MODE_SET_YEAR;
                else if (rel) mode_now = cdsc_pkg::MODE_SHOW_MONTH;
            end
            cdsc_pkg::MODE_SHOW_MONTH: begin
                f.seg0 = cdsc_pkg::SEG_M_GLYPH;
                f.seg2 = tens_glyph(mo);
                f.seg3 = ones_glyph(mo);
                if (lng) mode_now = cdsc_pkg::MODE_SET_MONTH;
                else if (rel) mode_now = cdsc_pkg::MODE_SHOW_DAY;
            end
            cdsc_pkg::MODE_SHOW_DAY: begin
                f.seg0 = HEX_GLYPH[cdsc_pkg::GLYPH_D_INDEX];
                f.seg2 = tens_glyph(dy);
                f.seg3 = ones_glyph(dy);
                if (lng) mode_now = cdsc_pkg::MODE_SET_DAY;
                else if (rel) mode_now = cdsc_pkg::MODE_SHOW_TIME;
            end
            cdsc_pkg::MODE_SET_HOURS: begin
                if (blink_lit) begin
                    f.seg0 = tens_glyph(hr);
                    f.seg1 = ones_glyph(hr);
                end
                f.seg2  = tens_glyph(mi);
                f.seg3  = ones_glyph(mi);
                f.colon = 1'b1;
                if (prs) mode_now = cdsc_pkg::MODE_SET_MINUTES;
                if (plus) begin
                    hr_w   = 5'(wrap_up(hr_w, 0, cdsc_pkg::HOUR_MAX));
                    edited = 1'b1;
                end
                if (minus) begin
                    hr_w   = 5'(wrap_down(hr_w, 0, cdsc_pkg::HOUR_MAX));
                    edited = 1'b1;
                end
            end
            cdsc_pkg::MODE_SET_MINUTES: begin
                f.seg0 = tens_glyph(hr);
                f.seg1 = ones_glyph(hr);
                if (blink_lit) begin
                    f.seg2 = tens_glyph(mi);
                    f.seg3 = ones_glyph(mi);
                end
                f.colon = 1'b1;
                if (prs) mode_now = cdsc_pkg::MODE_SET_YEAR;
                if (plus) begin
                    mi_w   = 6'(wrap_up(mi_w, 0, cdsc_pkg::MINUTE_MAX));
                    edited = 1'b1;
                end
                if (minus) begin
                    mi_w   = 6'(wrap_down(mi_w, 0, cdsc_pkg::MINUTE_MAX));
                    edited = 1'b1;
                end
            end
            cdsc_pkg::MODE_SET_YEAR: begin
                if (blink_lit) begin
                    f.seg0 = HEX_GLYPH[2];
                    f.seg1 = HEX_GLYPH[0];
                    f.seg2 = tens_glyph(yr);
                    f.seg3 = ones_glyph(yr);
                end
                if (prs) mode_now = cdsc_pkg::MODE_SET_MONTH;
                if (plus) begin
                    yr_w   = 7'(wrap_up(yr_w, 0, cdsc_pkg::YEAR_MAX));
                    edited = 1'b1;
                end
                if (minus) begin
                    yr_w   = 7'(wrap_down(yr_w, 0, cdsc_pkg::YEAR_MAX));
                    edited = 1'b1;
                end
            end
            cdsc_pkg::MODE_SET_MONTH: begin
                f.seg0 = cdsc_pkg::SEG_M_GLYPH;
                if (blink_lit) begin
                    f.seg2 = tens_glyph(mo);
                    f.seg3 = ones_glyph(mo);
                end
                if (prs) mode_now = cdsc_pkg::MODE_SET_DAY;
                if (plus) begin
                    mo_w   = 4'(wrap_up(mo_w, 1, cdsc_pkg::MONTH_MAX));
                    edited = 1'b1;
                end
                if (minus) begin
                    mo_w   = 4'(wrap_down(mo_w, 1, cdsc_pkg::MONTH_MAX));
                    edited = 1'b1;
                end
            end
            cdsc_pkg::MODE_SET_DAY: begin
                // A month outside one to twelve is treated as a long month.
                month_len = (mo >= 1 && mo <= 12) ? MONTH_LENGTHS[mo] : 31;
                if (mo == 2 && yr % 4 == 0) month_len++;
                f.seg0 = HEX_GLYPH[cdsc_pkg::GLYPH_D_INDEX];
                if (blink_lit) begin
                    f.seg2 = tens_glyph(dy);
                    f.seg3 = ones_glyph(dy);
                end
                if (prs) begin
                    mode_now     = cdsc_pkg::MODE_SHOW_TIME;
                    release_lock = 1'b1;
                end
                if (plus) begin
                    dy_w   = 5'(wrap_up(dy_w, 1, month_len));
                    edited = 1'b1;
                end
                if (minus) begin
                    dy_w   = 5'(wrap_down(dy_w, 1, month_len));
                    edited = 1'b1;
                end
            end
            default: begin
                f.seg0   = cdsc_pkg::SEG_DASH;
                f.seg1   = cdsc_pkg::SEG_DASH;
                f.seg2   = cdsc_pkg::SEG_DASH;
                f.seg3   = cdsc_pkg::SEG_DASH;
                mode_now = cdsc_pkg::MODE_SHOW_TIME;
            end
        endcase

        if (edited) begin
            blink_mark_ms = now_ms;
            blink_lit     = 1'b1;
            f.wr          = 1'b1;
            f.hour        = hr_w;
            f.minute      = mi_w;
            f.day         = dy_w;
            f.month       = mo_w;
            f.year        = yr_w;
        end
        return f;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_display_frame want;
        if (!i_rst_n) begin
            mode_now       = cdsc_pkg::MODE_SHOW_TIME;
            blink_mark_ms  = '0;
            blink_lit      = 1'b0;
            release_lock   = 1'b0;
            half_period_ms = cdsc_pkg::BLINK_HALF_RESET;
            modes_seen     = '0;
            expected_frames.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BLINK_HALF_ADDR)
                half_period_ms = pwdata[15:0];

            if (o_valid && i_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("digit0_segments", want.seg0, o_digit0_segments);
                    check_field("digit1_segments", want.seg1, o_digit1_segments);
                    check_field("digit2_segments", want.seg2, o_digit2_segments);
                    check_field("digit3_segments", want.seg3, o_digit3_segments);
                    check_field("colon_on", want.colon, o_colon_on);
                    check_field("write_clock", want.wr, o_write_clock);
                    check_field("new_hour", want.hour, o_new_hour);
                    check_field("new_minute", want.minute, o_new_minute);
                    check_field("new_day", want.day, o_new_day);
                    check_field("new_month", want.month, o_new_month);
                    check_field("new_year", want.year, o_new_year);
                    checked_count++;
                    if (want.wr) clock_writes++;
                end
            end

            if (i_valid && o_ready) begin
                modes_seen[mode_now] = 1'b1;
                expected_frames.push_back(render_and_edit(
                    i_time_ms, i_cur_hour, i_cur_minute, i_cur_day, i_cur_month,
                    i_cur_year, i_set_long_press, i_set_released, i_set_pressed,
                    i_plus_pressed, i_minus_pressed));
            end
        end
        pending_count = expected_frames.size();
    end

endmodule

FILE: verif/clock_display_set_controller_tb.sv
// ============================================================================
// clock_display_set_controller_tb
// Drives service ticks into the clock display and set controller: a directed
// walk through every mode and wrap case, then random button traffic under
// several blink half periods, with random stalls on both channels and one
// long output hold. Checking is done by the display checker beside the block.
// ============================================================================
module clock_display_set_controller_tb;

    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES     = 8;
    localparam logic [2:0]  BLINK_HALF_ADDR  = 3'(4 * cdsc_pkg::REG_BLINK_HALF);

    // Button events of one tick: long press, release, press, plus, minus.
    localparam logic [4:0]  EV_NONE    = 5'b00000;
    localparam logic [4:0]  EV_LONG    = 5'b10000;
    localparam logic [4:0]  EV_RELEASE = 5'b01000;
    localparam logic [4:0]  EV_PRESS   = 5'b00100;
    localparam logic [4:0]  EV_PLUS    = 5'b00010;
    localparam logic [4:0]  EV_MINUS   = 5'b00001;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_time_ms;
    logic [4:0]  i_cur_hour;
    logic [5:0]  i_cur_minute;
    logic [4:0]  i_cur_day;
    logic [3:0]  i_cur_month;
    logic [6:0]  i_cur_year;
    logic        i_set_long_press;
    logic        i_set_released;
    logic        i_set_pressed;
    logic        i_plus_pressed;
    logic        i_minus_pressed;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_digit0_segments;
    logic [7:0]  o_digit1_segments;
    logic [7:0]  o_digit2_segments;
    logic [7:0]  o_digit3_segments;
    logic        o_colon_on;
    logic        o_write_clock;
    logic [4:0]  o_new_hour;
    logic [5:0]  o_new_minute;
    logic [4:0]  o_new_day;
    logic [3:0]  o_new_month;
    logic [6:0]  o_new_year;

    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          clock_writes;
    logic [8:0]  modes_seen;

    logic [31:0] now_ms;
    int          half_ms;
    int          ticks_sent;
    int          blink_settings;
    int          hold_count;
    int          cycle_count;
    bit          calm;
    bit          long_hold_req;

    clock_display_set_controller dut (.*);

    cdsc_display_checker checker_i (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one; none while calm.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
                hold_count++;
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                stall_left = idle_length();
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Called and returns at a falling edge; holds the tick until its transfer.
    task automatic push_tick(input logic [31:0] ms, input logic [4:0] hr, input logic [5:0] mi,
                             input logic [4:0] dy, input logic [3:0] mo, input logic [6:0] yr,
                             input logic [4:0] ev);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_time_ms        <= ms;
        i_cur_hour       <= hr;
        i_cur_minute     <= mi;
        i_cur_day        <= dy;
        i_cur_month      <= mo;
        i_cur_year       <= yr;
        i_set_long_press <= ev[4];
        i_set_released   <= ev[3];
        i_set_pressed    <= ev[2];
        i_plus_pressed   <= ev[1];
        i_minus_pressed  <= ev[0];
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Directed ticks step the clock by 300 ms so the blink phase alternates.
    task automatic step_tick(input logic [4:0] hr, input logic [5:0] mi, input logic [4:0] dy,
                             input logic [3:0] mo, input logic [6:0] yr, input logic [4:0] ev);
        now_ms = now_ms + 32'd300;
        push_tick(now_ms, hr, mi, dy, mo, yr, ev);
    endtask

    task automatic random_tick();
        int          r;
        logic [4:0]  ev;
        logic [4:0]  hr;
        logic [5:0]  mi;
        logic [4:0]  dy;
        logic [3:0]  mo;
        logic [6:0]  yr;
        if ($urandom_range(0, 49) == 0) now_ms = $urandom();
        else now_ms = now_ms + 32'($urandom_range(0, half_ms + half_ms / 2));
        // Now and then a field carries any value its width allows.
        hr = ($urandom_range(0, 11) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 23));
        mi = ($urandom_range(0, 11) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 59));
        dy = ($urandom_range(0, 11) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 31));
        mo = ($urandom_range(0, 11) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 12));
        yr = ($urandom_range(0, 11) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 99));
        r = $urandom_range(0, 99);
        if (r < 40)      ev = EV_NONE;
        else if (r < 50) ev = EV_RELEASE;
        else if (r < 57) ev = EV_LONG;
        else if (r < 69) ev = EV_PRESS;
        else if (r < 80) ev = EV_PLUS;
        else if (r < 91) ev = EV_MINUS;
        else if (r < 95) ev = EV_PLUS | EV_MINUS;
        else             ev = 5'($urandom());
        push_tick(now_ms, hr, mi, dy, mo, yr, ev);
    endtask

    task automatic run_random(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3) && (n < count / 3 + 60);
            if (with_hold && n == count / 2) long_hold_req = 1'b1;
            random_tick();
        end
        calm = 1'b0;
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0 || long_hold_req);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_blink_half(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLINK_HALF_ADDR;
        pwdata  <= {16'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        half_ms = v;
        blink_settings++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_valid          = 1'b0;
        i_time_ms        = '0;
        i_cur_hour       = '0;
        i_cur_minute     = '0;
        i_cur_day        = '0;
        i_cur_month      = '0;
        i_cur_year       = '0;
        i_set_long_press = 1'b0;
        i_set_released   = 1'b0;
        i_set_pressed    = 1'b0;
        i_plus_pressed   = 1'b0;
        i_minus_pressed  = 1'b0;
        now_ms           = '0;
        half_ms          = cdsc_pkg::BLINK_HALF_RESET;
        blink_settings   = 1;
        calm             = 1'b0;
        long_hold_req    = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed walk under the reset half period.
        step_tick(5'd0, 6'd0, 5'd1, 4'd1, 7'd0, EV_NONE);
        step_tick(5'd23, 6'd59, 5'd31, 4'd12, 7'd99, EV_NONE);
        step_tick(5'd31, 6'd63, 5'd31, 4'd15, 7'd127, EV_NONE);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd25, EV_RELEASE);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd99, EV_RELEASE);
        step_tick(5'd12, 6'd34, 5'd15, 4'd12, 7'd25, EV_RELEASE);
        step_tick(5'd12, 6'd34, 5'd31, 4'd6, 7'd25, EV_RELEASE);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd25, EV_LONG);
        step_tick(5'd23, 6'd34, 5'd15, 4'd6, 7'd25, EV_PLUS);
        step_tick(5'd0, 6'd34, 5'd15, 4'd6, 7'd25, EV_MINUS);
        step_tick(5'd31, 6'd34, 5'd15, 4'd6, 7'd25, EV_PLUS | EV_MINUS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd25, EV_PRESS);
        step_tick(5'd12, 6'd59, 5'd15, 4'd6, 7'd25, EV_PLUS);
        step_tick(5'd12, 6'd63, 5'd15, 4'd6, 7'd25, EV_MINUS);
        now_ms = 32'hFFFF_FF00;
        step_tick(5'd12, 6'd0, 5'd15, 4'd6, 7'd25, EV_PRESS | EV_MINUS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd99, EV_PLUS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd127, EV_MINUS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd0, EV_MINUS | EV_PRESS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd12, 7'd25, EV_PLUS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd1, 7'd25, EV_MINUS | EV_PRESS);
        step_tick(5'd12, 6'd34, 5'd29, 4'd2, 7'd24, EV_PLUS);
        step_tick(5'd12, 6'd34, 5'd1, 4'd2, 7'd23, EV_MINUS);
        step_tick(5'd12, 6'd34, 5'd31, 4'd0, 7'd25, EV_PLUS);
        step_tick(5'd12, 6'd34, 5'd1, 4'd13, 7'd25, EV_MINUS | EV_PRESS);
        step_tick(5'd12, 6'd34, 5'd15, 4'd6, 7'd25, EV_RELEASE);
        drain_results();

        write_blink_half(16'd1);
        run_random(400, 1'b0);
        drain_results();

        write_blink_half(16'd65535);
        run_random(400, 1'b1);
        drain_results();

        write_blink_half(16'($urandom_range(2, 5000)));
        run_random(500, 1'b0);
        drain_results();

        write_blink_half(cdsc_pkg::BLINK_HALF_RESET);
        run_random(450, 1'b0);
        drain_results();

        $display("Sent %0d ticks under %0d blink half periods; %0d results checked,",
                 ticks_sent, blink_settings, checked_count);
        $display("%0d clock writes, mode codes visited %b, long output holds %0d.",
                 clock_writes, modes_seen, hold_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches.", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
